// File: src/session_index_table_macros.svh
// Assertion macros shared by the session index table files.
`ifndef SESSION_INDEX_TABLE_MACROS_SVH
`define SESSION_INDEX_TABLE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/sit_pkg.sv
// Shared types, constants and helper functions of the session index table.
package sit_pkg;

  // Table geometry
  localparam int TABLE_SIZE  = 1024;
  localparam int HANDLE_BITS = 16;
  localparam int SLOT_W      = $clog2(TABLE_SIZE);
  localparam int COL_W       = (SLOT_W < 5) ? SLOT_W : 5;
  localparam int MAP_W       = 1 << COL_W;
  localparam int ROWS        = TABLE_SIZE / MAP_W;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [31:0] SLOT_MASK  = 32'(TABLE_SIZE - 1);
  localparam logic [31:0] SIZE_INDEX = 32'(TABLE_SIZE);
  localparam logic [15:0] HANDLE_MASK =
    (HANDLE_BITS >= 16) ? 16'hFFFF : 16'((33'h1 << HANDLE_BITS) - 33'h1);

  // Request codes
  localparam logic [2:0] REQ_ALLOC_HS = 3'd0;
  localparam logic [2:0] REQ_ALLOC_KP = 3'd1;
  localparam logic [2:0] REQ_LOOKUP   = 3'd2;
  localparam logic [2:0] REQ_DELETE   = 3'd3;
  localparam logic [2:0] REQ_RETYPE   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Entry kinds
  localparam logic KIND_HS = 1'b0;
  localparam logic KIND_KP = 1'b1;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_DELETE = 3'd2,
    OP_RETYPE = 3'd3,
    OP_IGNORE = 3'd4
  } sit_op_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] index_in;
    logic [31:0] random_word;
    logic [15:0] peer_in;
    logic [15:0] handshake_in;
    logic [15:0] keypair_in;
  } sit_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] new_index;
    logic        kind_out;
    logic [15:0] peer_out;
    logic [15:0] handshake_out;
    logic [15:0] keypair_out;
  } sit_out_t;

  // Classified request handed from front to back
  typedef struct packed {
    sit_op_t     op;
    logic        kind;
    logic        idx_nz;
    logic        rnd_nz;
    logic [31:0] index;
    logic [31:0] rnd;
    logic [15:0] peer;
    logic [15:0] hs;
    logic [15:0] kp;
  } sit_cmd_t;

  typedef struct packed {
    logic     valid;
    sit_cmd_t cmd;
  } sit_q_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic clearing;
    logic res_push;
  } sit_mon_t;

  typedef struct packed {
    logic [31:0] index;
    logic        kind;
    logic [15:0] peer;
    logic [15:0] handshake;
    logic [15:0] keypair;
  } sit_entry_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [31:0] idx);
    return idx[SLOT_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] row_of(input logic [SLOT_W-1:0] slot);
    return ROW_W'(slot >> COL_W);
  endfunction

  function automatic logic [SLOT_W-1:0] make_slot(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return SLOT_W'({row, col});
  endfunction

  // Lowest clear bit of one occupancy row
  function automatic logic [COL_W-1:0] first_zero(input logic [MAP_W-1:0] m);
    logic [COL_W-1:0] r;
    r = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (!m[i]) r = COL_W'(i);
    end
    return r;
  endfunction

  // Lowest row that still has a free slot
  function automatic logic [ROW_W-1:0] first_open(input logic [ROWS-1:0] f);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!f[i]) r = ROW_W'(i);
    end
    return r;
  endfunction

endpackage

// File: src/session_index_table.sv
// Top level of the session index table: front end, back end and checks.
// A direct-mapped table of 32-bit session indices with 1024 slots. Requests
// enter through a two-deep request queue and results leave through a two-deep
// result queue, one result per request in request order. Lookup, delete,
// retype and an allocation that can use its random word pass through the back
// end as one synchronous read of the entry memory and the occupancy map, then
// the check and write-back. An allocation that falls back to the lowest free
// slot adds a second read of the occupancy map, which fetches the first row
// that still has room, before its write-back. After reset a clearing pass
// writes the occupancy map one row a cycle over all ROWS = 32 rows, and full
// stays high until it ends.
module session_index_table
  import sit_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  sit_in_t  in_data,
  input  logic     pop,
  output logic     empty,
  output sit_out_t out_data
);

`include "session_index_table_macros.svh"

  sit_q_t   cmd_q;
  logic     cmd_pop;
  sit_mon_t mon;

  sit_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .hold    (mon.clearing),
    .cmd_pop (cmd_pop),
    .cmd_q   (cmd_q)
  );

  sit_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_q    (cmd_q),
    .cmd_pop  (cmd_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data),
    .mon      (mon)
  );

  // Consistency checks between front, back and ports
  `SIT_ASSERT_NOW(a_no_accept_clear, push && !full, !mon.clearing, "transaction accepted during clear")
  `SIT_ASSERT_NOW(a_no_result_clear, mon.clearing, empty, "result present during clear")
  `SIT_ASSERT_NOW(a_pop_valid, cmd_pop, cmd_q.valid, "command popped from empty queue")
  `SIT_ASSERT_NEXT(a_result_shown, mon.res_push, !empty, "pushed result not visible")

endmodule

// File: src/sit_front.sv
// Request front end: classifies requests and queues them for the back end.
module sit_front
  import sit_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    full,
  input  sit_in_t in_data,
  input  logic    hold,
  input  logic    cmd_pop,
  output sit_q_t  cmd_q
);

  sit_cmd_t   cls;
  sit_cmd_t   q_mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;

  // Classify the request and trim the handles
  always_comb begin
    cls.kind   = KIND_HS;
    cls.idx_nz = |in_data.index_in;
    cls.rnd_nz = |in_data.random_word;
    cls.index  = in_data.index_in;
    cls.rnd    = in_data.random_word;
    cls.peer   = in_data.peer_in & HANDLE_MASK;
    cls.hs     = in_data.handshake_in & HANDLE_MASK;
    cls.kp     = in_data.keypair_in & HANDLE_MASK;
    case (in_data.req_type)
      REQ_ALLOC_HS: begin
        cls.op = OP_ALLOC;
        cls.kp = '0;
      end
      REQ_ALLOC_KP: begin
        cls.op   = OP_ALLOC;
        cls.kind = KIND_KP;
        cls.hs   = '0;
      end
      REQ_LOOKUP: cls.op = OP_LOOKUP;
      REQ_DELETE: cls.op = OP_DELETE;
      REQ_RETYPE: cls.op = OP_RETYPE;
      default:    cls.op = OP_IGNORE;
    endcase
  end

  assign full   = (cnt_r == 2'd2) || hold;
  assign accept = push && !full;

  // Advance queue pointers and count
  always_comb begin
    wp_nxt  = accept ? ~wp_r : wp_r;
    rp_nxt  = cmd_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, accept} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (accept) q_mem_r[wp_r] <= cls;
  end

  assign cmd_q.valid = (cnt_r != 2'd0);
  assign cmd_q.cmd   = q_mem_r[rp_r];

endmodule

// File: src/sit_back.sv
// Table back end: occupancy map, entry memory, sequencer and result queue.
module sit_back
  import sit_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  sit_q_t   cmd_q,
  output logic     cmd_pop,
  input  logic     pop,
  output logic     empty,
  output sit_out_t out_data,
  output sit_mon_t mon
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CHECK = 4'b0100,
    S_FILL  = 4'b1000
  } sit_state_t;

  sit_state_t        state_r, state_nxt;
  sit_cmd_t          cmd_r, cmd_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ROW_W-1:0]  fill_row_r, fill_row_nxt;
  logic [ROW_W-1:0]  clr_row_r, clr_row_nxt;
  logic [ROWS-1:0]   row_full_r;

  // Memories and their ports
  logic [MAP_W-1:0]  map_mem [ROWS];
  sit_entry_t        ent_mem [TABLE_SIZE];
  logic [MAP_W-1:0]  map_rd_r;
  sit_entry_t        ent_rd_r;
  logic              map_re, map_we, ent_re, ent_we;
  logic [ROW_W-1:0]  map_ra, map_wa;
  logic [MAP_W-1:0]  map_wd;
  logic [SLOT_W-1:0] ent_ra, ent_wa;
  sit_entry_t        ent_wd;

  // Result queue
  sit_out_t          res_mem_r [2];
  logic              res_wp_r, res_rp_r;
  logic [1:0]        res_cnt_r;
  logic              res_push, res_pop, res_space;
  sit_out_t          res_d;

  // Lookup and allocation helpers
  logic [COL_W-1:0]  cur_col, fill_col;
  logic [ROW_W-1:0]  cur_row, open_row;
  logic [MAP_W-1:0]  cur_bit, fill_bit;
  logic [SLOT_W-1:0] fill_slot;
  logic [31:0]       fill_raw, fill_idx;
  logic              used, match, any_open;

  assign cur_col   = slot_r[COL_W-1:0];
  assign cur_row   = row_of(slot_r);
  assign cur_bit   = MAP_W'(1) << cur_col;
  assign used      = map_rd_r[cur_col];
  assign match     = used && (ent_rd_r.index == cmd_r.index);
  assign any_open  = ~&row_full_r;
  assign open_row  = first_open(row_full_r);
  assign fill_col  = first_zero(map_rd_r);
  assign fill_bit  = MAP_W'(1) << fill_col;
  assign fill_slot = make_slot(fill_row_r, fill_col);
  assign fill_raw  = (cmd_r.rnd & ~SLOT_MASK) | 32'(fill_slot);
  assign fill_idx  = (fill_raw == 32'd0) ? SIZE_INDEX : fill_raw;
  assign res_space = (res_cnt_r != 2'd2);

  // Sequence one request through read, check and optional fill
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    slot_nxt     = slot_r;
    fill_row_nxt = fill_row_r;
    clr_row_nxt  = clr_row_r;
    cmd_pop      = 1'b0;
    map_re       = 1'b0;
    map_ra       = cur_row;
    ent_re       = 1'b0;
    ent_ra       = slot_r;
    map_we       = 1'b0;
    map_wa       = cur_row;
    map_wd       = map_rd_r;
    ent_we       = 1'b0;
    ent_wa       = slot_r;
    ent_wd       = ent_rd_r;
    res_push     = 1'b0;
    res_d        = '0;
    res_d.status = ST_MISS;
    case (state_r)
      S_CLEAR: begin
        map_we      = 1'b1;
        map_wa      = clr_row_r;
        map_wd      = '0;
        clr_row_nxt = clr_row_r + ROW_W'(1);
        if (clr_row_r == ROW_W'(ROWS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_q.valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd_q.cmd;
          slot_nxt  = (cmd_q.cmd.op == OP_ALLOC) ? slot_of(cmd_q.cmd.rnd)
                                                 : slot_of(cmd_q.cmd.index);
          map_re    = 1'b1;
          map_ra    = row_of(slot_nxt);
          ent_re    = 1'b1;
          ent_ra    = slot_nxt;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (res_space) begin
          state_nxt = S_IDLE;
          res_push  = 1'b1;
          case (cmd_r.op)
            OP_ALLOC: begin
              if (cmd_r.rnd_nz && !used) begin
                // Take the supplied draw directly
                map_we           = 1'b1;
                map_wd           = map_rd_r | cur_bit;
                ent_we           = 1'b1;
                ent_wd.index     = cmd_r.rnd;
                ent_wd.kind      = cmd_r.kind;
                ent_wd.peer      = cmd_r.peer;
                ent_wd.handshake = cmd_r.hs;
                ent_wd.keypair   = cmd_r.kp;
                res_d.status     = ST_OK;
                res_d.new_index  = cmd_r.rnd;
              end else if (any_open) begin
                // Fetch the lowest open row and search it next cycle
                res_push     = 1'b0;
                map_re       = 1'b1;
                map_ra       = open_row;
                fill_row_nxt = open_row;
                state_nxt    = S_FILL;
              end else begin
                res_d.status = ST_FULL;
              end
            end
            OP_LOOKUP: begin
              if (match) begin
                res_d.status        = ST_OK;
                res_d.kind_out      = ent_rd_r.kind;
                res_d.peer_out      = ent_rd_r.peer;
                res_d.handshake_out = ent_rd_r.handshake;
                res_d.keypair_out   = ent_rd_r.keypair;
              end
            end
            OP_DELETE: begin
              if (cmd_r.idx_nz && match) begin
                map_we       = 1'b1;
                map_wd       = map_rd_r & ~cur_bit;
                res_d.status = ST_OK;
              end
            end
            OP_RETYPE: begin
              if (cmd_r.idx_nz && match) begin
                ent_we         = 1'b1;
                ent_wd.kind    = KIND_KP;
                ent_wd.keypair = cmd_r.kp;
                res_d.status   = ST_OK;
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        if (res_space) begin
          map_we           = 1'b1;
          map_wa           = fill_row_r;
          map_wd           = map_rd_r | fill_bit;
          ent_we           = 1'b1;
          ent_wa           = fill_slot;
          ent_wd.index     = fill_idx;
          ent_wd.kind      = cmd_r.kind;
          ent_wd.peer      = cmd_r.peer;
          ent_wd.handshake = cmd_r.hs;
          ent_wd.keypair   = cmd_r.kp;
          res_push         = 1'b1;
          res_d.status     = ST_OK;
          res_d.new_index  = fill_idx;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_row_r  <= '0;
      row_full_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_row_r <= clr_row_nxt;
      if (map_we) row_full_r[map_wa] <= &map_wd;
    end
  end

  // Hold the current request
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    slot_r     <= slot_nxt;
    fill_row_r <= fill_row_nxt;
  end

  // Occupancy map memory
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (map_re) map_rd_r <= map_mem[map_ra];
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) ent_rd_r <= ent_mem[ent_ra];
  end

  // Result queue
  assign empty    = (res_cnt_r == 2'd0);
  assign res_pop  = pop && !empty;
  assign out_data = res_mem_r[res_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wp_r  <= 1'b0;
      res_rp_r  <= 1'b0;
      res_cnt_r <= 2'd0;
    end else begin
      if (res_push) res_wp_r <= ~res_wp_r;
      if (res_pop)  res_rp_r <= ~res_rp_r;
      res_cnt_r <= res_cnt_r + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) res_mem_r[res_wp_r] <= res_d;
  end

  assign mon.clearing = (state_r == S_CLEAR);
  assign mon.res_push = res_push;

endmodule
